// ===== rtl/fmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Framed message checker package
// Frame layout constants, item types, status codes and the CRC-32 byte step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fmc_pkg;

   // frame geometry
   localparam int MAX_PAYLOAD = 1024;
   localparam int TYPE_LEN    = 16;
   localparam int SEQ_POS     = 24;
   localparam int TYPE_POS    = 28;
   localparam int LEN_POS     = TYPE_POS + TYPE_LEN;
   localparam int PAY_POS     = LEN_POS + 4;
   localparam int MIN_FRAME   = PAY_POS + 8;
   localparam int POS_LIMIT   = MIN_FRAME + MAX_PAYLOAD + 1;
   localparam int POS_W       = $clog2(POS_LIMIT + 1);
   localparam int SENSOR_LEN  = 11;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 10;
   localparam int LENGTH_W = 11;
   localparam int WORD_W   = 32;
   localparam int REL_W    = WORD_W + 2;

   localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB88320;

   typedef enum logic [1:0] {
      KIND_TYPE    = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_STATUS  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_SHORT     = 4'd1,
      ST_MAGIC     = 4'd2,
      ST_MAIN_VER  = 4'd3,
      ST_SUB_VER   = 4'd4,
      ST_CRC_FLAG  = 4'd5,
      ST_CODE_FLAG = 4'd6,
      ST_CRC       = 4'd7,
      ST_CODE      = 4'd8,
      ST_LENGTH    = 4'd9,
      ST_OVERFLOW  = 4'd10
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   data;
      logic [INDEX_W-1:0]  index;
      status_type          status;
      logic [WORD_W-1:0]   seq;
      logic [LENGTH_W-1:0] length;
      logic                sensor;
   } rsp_type;

   function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
      logic [BYTE_W-1:0] val;
      case (idx)
         2'd0:    val = 8'h45;
         2'd1:    val = 8'h43;
         2'd2:    val = 8'h45;
         default: val = 8'h42;
      endcase
      return val;
   endfunction

   // "easysensor" plus terminating zero
   function automatic logic [BYTE_W-1:0] sensor_char(input logic [3:0] idx);
      logic [BYTE_W-1:0] val;
      case (idx)
         4'd0:    val = 8'h65;
         4'd1:    val = 8'h61;
         4'd2:    val = 8'h73;
         4'd3:    val = 8'h79;
         4'd4:    val = 8'h73;
         4'd5:    val = 8'h65;
         4'd6:    val = 8'h6E;
         4'd7:    val = 8'h73;
         4'd8:    val = 8'h6F;
         4'd9:    val = 8'h72;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // reflected CRC-32, one byte
   function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] c;
      c = acc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
      for (int i = 0; i < BYTE_W; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // check code built from the received CRC bytes
   function automatic logic [WORD_W-1:0] make_code(input logic [WORD_W-1:0] crc);
      logic [BYTE_W-1:0] q0, q1, q2, q3;
      q0 = {crc[20:16], 3'b000};
      q1 = {2'b00, crc[31:26]};
      q2 = {crc[2:0], 5'b00000};
      q3 = {4'b0000, crc[15:12]};
      return {q3, q2, q1, q0};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fmc_ifs.sv =====
// ----------------------------------------------------------------------------
// Framed message checker channels
// Valid/ready interfaces for the received byte stream and the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fmc_req_if;
   import fmc_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              frame_end;

   modport source (output valid, rx_byte, frame_end, input ready);
   modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

interface fmc_rsp_if;
   import fmc_pkg::*;
   logic                valid;
   logic                ready;
   kind_type            result_kind;
   logic [BYTE_W-1:0]   out_byte;
   logic [INDEX_W-1:0]  byte_index;
   status_type          status_code;
   logic [WORD_W-1:0]   sequence_number;
   logic [LENGTH_W-1:0] payload_length;
   logic                is_sensor;

   modport source (output valid, result_kind, out_byte, byte_index, status_code,
                   sequence_number, payload_length, is_sensor, input ready);
   modport sink   (input valid, result_kind, out_byte, byte_index, status_code,
                   sequence_number, payload_length, is_sensor, output ready);
endinterface

`default_nettype wire

// ===== rtl/framed_message_checker.sv =====
// ----------------------------------------------------------------------------
// Framed message checker
// Each accepted byte waits in the input register; its result, if any, is then registered in the result register.
// Throughput: one byte per cycle, sustained while the result side takes each result.
// Reset: synchronous; empties both registers and rearms the frame parser.
// After each end-of-frame status the parser rearms for the next frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module framed_message_checker (
   input wire logic clock,
   input wire logic reset,
   fmc_req_if.sink   req_item,
   fmc_rsp_if.source rsp_item
);
   import fmc_pkg::*;

   // Input register: holds the accepted byte while the parser works on it.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_item_ff;

   // Result register: parts the result side from the input side.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic    has_result, out_free, s1_adv, req_acc;
   rsp_type result;

   // The held byte moves on when it makes no item, or the result slot is
   // free or being emptied this cycle. Bytes inside a frame that are neither
   // type nor payload never wait on the result side.
   assign out_free = !rsp_valid_ff || rsp_item.ready;
   assign s1_adv   = s1_valid_ff && (!has_result || out_free);

   assign req_item.ready = !s1_valid_ff || s1_adv;
   assign req_acc        = req_item.valid && req_item.ready;

   assign s1_valid_in  = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_adv && has_result) ? 1'b1 :
                         (rsp_item.ready ? 1'b0 : rsp_valid_ff);

   fmc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (s1_adv),
      .item       (s1_item_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_item_ff <= '{data: req_item.rx_byte, last: req_item.frame_end};
      end
      if (s1_adv && has_result) begin
         rsp_ff <= result;
      end
   end

   assign rsp_item.valid           = rsp_valid_ff;
   assign rsp_item.result_kind     = rsp_ff.kind;
   assign rsp_item.out_byte        = rsp_ff.data;
   assign rsp_item.byte_index      = rsp_ff.index;
   assign rsp_item.status_code     = rsp_ff.status;
   assign rsp_item.sequence_number = rsp_ff.seq;
   assign rsp_item.payload_length  = rsp_ff.length;
   assign rsp_item.is_sensor       = rsp_ff.sensor;

`ifndef SYNTHESIS
   // a stalled byte stays put until the parser takes it
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("input register changed while stalled");

   // a result only appears from a parser step that makes one
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_adv && has_result))
      else $error("result without a producing byte");

   // both registers come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !s1_valid_ff && !rsp_valid_ff)
      else $error("registers not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== rtl/fmc_parser.sv =====
// ----------------------------------------------------------------------------
// Framed message checker parser
// Per-frame state and the combinational byte step: field capture, CRC, status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmc_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire fmc_pkg::req_type item,
   output logic                  has_result,
   output fmc_pkg::rsp_type      result
);
   import fmc_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in, count, off, type_idx;
   status_type        error_ff, error_in, st;
   logic [WORD_W-1:0] crc_ff, crc_in;
   logic [WORD_W-1:0] dl_ff, dl_in;
   logic [WORD_W-1:0] seq_ff, seq_in;
   logic [WORD_W-1:0] rcrc_ff, rcrc_in;
   logic [WORD_W-1:0] rcode_ff, rcode_in;
   logic              match_ff, match_in;
   logic [REL_W-1:0]  crc_start, rel, cnt_rel;
   logic              dl_over, fwd;
   kind_type          fwd_kind;
   logic [INDEX_W-1:0] fwd_index;
   logic [BYTE_W-1:0] b;

   assign b         = item.data;
   assign crc_start = REL_W'(PAY_POS) + REL_W'(dl_ff);
   assign rel       = REL_W'(pos_ff) - crc_start;
   assign off       = pos_ff - POS_W'(PAY_POS);
   assign type_idx  = pos_ff - POS_W'(TYPE_POS);
   assign dl_over   = dl_ff > WORD_W'(MAX_PAYLOAD);
   assign count     = (pos_ff < POS_W'(POS_LIMIT)) ? pos_ff + POS_W'(1) : pos_ff;
   assign cnt_rel   = REL_W'(count) - crc_start;

   // field capture and header checks
   always_comb begin
      error_in  = error_ff;
      dl_in     = dl_ff;
      seq_in    = seq_ff;
      rcrc_in   = rcrc_ff;
      rcode_in  = rcode_ff;
      match_in  = match_ff;
      fwd       = 1'b0;
      fwd_kind  = KIND_TYPE;
      fwd_index = '0;
      if (pos_ff < POS_W'(4)) begin
         if (b != magic_byte(pos_ff[1:0]) && error_ff == ST_OK) error_in = ST_MAGIC;
      end else if (pos_ff < POS_W'(8)) begin
         if (b != 8'd1 && error_ff == ST_OK) begin
            case (pos_ff[1:0])
               2'd0:    error_in = ST_MAIN_VER;
               2'd1:    error_in = ST_SUB_VER;
               2'd2:    error_in = ST_CRC_FLAG;
               default: error_in = ST_CODE_FLAG;
            endcase
         end
      end else if (pos_ff >= POS_W'(SEQ_POS) && pos_ff < POS_W'(SEQ_POS + 4)) begin
         seq_in = {seq_ff[WORD_W-BYTE_W-1:0], b};
      end else if (pos_ff >= POS_W'(TYPE_POS) && pos_ff < POS_W'(LEN_POS)) begin
         fwd       = 1'b1;
         fwd_kind  = KIND_TYPE;
         fwd_index = INDEX_W'(type_idx);
         if (type_idx < POS_W'(SENSOR_LEN) && b != sensor_char(type_idx[3:0])) begin
            match_in = 1'b0;
         end
      end else if (pos_ff >= POS_W'(LEN_POS) && pos_ff < POS_W'(PAY_POS)) begin
         dl_in = {dl_ff[WORD_W-BYTE_W-1:0], b};
      end else if (pos_ff >= POS_W'(PAY_POS)) begin
         if (WORD_W'(off) < dl_ff && off < POS_W'(MAX_PAYLOAD)) begin
            fwd       = 1'b1;
            fwd_kind  = KIND_PAYLOAD;
            fwd_index = INDEX_W'(off);
         end
         if (!dl_over && !rel[REL_W-1]) begin
            if (rel[REL_W-2:2] == '0) begin
               rcrc_in = {rcrc_ff[WORD_W-BYTE_W-1:0], b};
            end else if (rel[REL_W-2:3] == '0) begin
               rcode_in = {rcode_ff[WORD_W-BYTE_W-1:0], b};
            end
         end
      end
   end

   // CRC runs over everything ahead of the CRC field
   assign crc_in = (pos_ff < POS_W'(PAY_POS) || rel[REL_W-1]) ? crc_byte(crc_ff, b) : crc_ff;

   // end-of-frame status: a short frame overrides all, else the first error wins
   always_comb begin
      st = error_in;
      if (count <= POS_W'(MIN_FRAME)) begin
         st = ST_SHORT;
      end else if (error_in == ST_OK) begin
         if (dl_over) begin
            st = ST_OVERFLOW;
         end else if (cnt_rel[REL_W-1] || cnt_rel[REL_W-2:3] == '0) begin
            st = ST_LENGTH;
         end else if (rcrc_in != ~crc_in) begin
            st = ST_CRC;
         end else if (rcode_in != make_code(rcrc_in)) begin
            st = ST_CODE;
         end else if (cnt_rel != REL_W'(8)) begin
            st = ST_LENGTH;
         end
      end
   end

   always_comb begin
      result = '0;
      if (item.last) begin
         has_result    = 1'b1;
         result.kind   = KIND_STATUS;
         result.status = st;
         result.seq    = seq_in;
         if (st == ST_OK) begin
            result.length = dl_ff[LENGTH_W-1:0];
            result.sensor = match_in;
         end
      end else begin
         has_result   = fwd;
         result.kind  = fwd_kind;
         result.data  = b;
         result.index = fwd_index;
      end
   end

   assign pos_in = count;

   always_ff @(posedge clock) begin
      if (reset || (step && item.last)) begin
         pos_ff   <= '0;
         error_ff <= ST_OK;
         crc_ff   <= '1;
         dl_ff    <= '0;
         seq_ff   <= '0;
         rcrc_ff  <= '0;
         rcode_ff <= '0;
         match_ff <= 1'b1;
      end else if (step) begin
         pos_ff   <= pos_in;
         error_ff <= error_in;
         crc_ff   <= crc_in;
         dl_ff    <= dl_in;
         seq_ff   <= seq_in;
         rcrc_ff  <= rcrc_in;
         rcode_ff <= rcode_in;
         match_ff <= match_in;
      end
   end

endmodule

`default_nettype wire

// ===== bench/tb_framed_message_checker.sv =====
// ----------------------------------------------------------------------------
// Framed message checker testbench
// Streams received frames into the checker one byte at a time: well-formed
// frames with random content, frames broken in the magic, version or flag
// bytes, CRC, code or length, oversized and overlong frames, and plain noise.
// A predictor tracks the parse of every accepted byte; each forwarded byte
// or end-of-frame status is compared with it in order. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_framed_message_checker;
   import fmc_pkg::*;

   localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no transfer
   localparam int unsigned SETTLE_CYCLES = 6;     // result latency plus margin
   localparam int unsigned PHASE_ITEMS   = 220;
   localparam int unsigned MAX_REPORTS   = 30;
   localparam int unsigned VER_POS       = 4;     // main version, then sub, flags

   localparam logic [31:0] MAGIC_WORD  = 32'h4543_4542;
   localparam logic [79:0] SENSOR_NAME = "easysensor";

   typedef enum int {
      FR_GOOD, FR_MAGIC, FR_MAIN_VER, FR_SUB_VER, FR_CRC_FLAG, FR_CODE_FLAG,
      FR_BAD_CRC, FR_BAD_CODE, FR_CUT_TAIL, FR_EXTRA, FR_OVERFLOW, FR_SHORT,
      FR_NOISE
   } frame_kind;

   typedef enum int {
      TY_SENSOR, TY_UNTERMINATED, TY_MISSPELT, TY_ARBITRARY, TY_ANY
   } type_pick;

   logic clock;
   logic reset;

   fmc_req_if req_if ();
   fmc_rsp_if rsp_if ();

   framed_message_checker dut (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_if),
      .rsp_item (rsp_if)
   );

   req_type     byte_queue[$];     // frame bytes waiting to be sent
   rsp_type     expected_rsp[$];   // predicted results, oldest first
   int unsigned items_queued;
   int unsigned errors_seen;
   int unsigned stall_cycles;
   int unsigned src_idle_pct;
   int unsigned sink_idle_pct;

   // parser state as the checker should hold it
   int unsigned pos_cnt;
   status_type  err_first;
   logic [31:0] crc_run;
   logic [31:0] crc_done;
   logic [31:0] decl_len;
   logic [31:0] seq_acc;
   logic [31:0] crc_seen;
   logic [31:0] code_seen;
   logic        type_ok;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] sensor_byte(input int unsigned i);
      return (i < SENSOR_LEN - 1) ? SENSOR_NAME[79 - 8*i -: 8] : 8'h00;
   endfunction

   // reflected CRC-32, one input bit at a time
   function automatic logic [31:0] crc_update(input logic [31:0] acc,
                                              input logic [7:0] b);
      logic [31:0] c;
      logic        fb;
      c = acc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c  = c >> 1;
         if (fb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   function automatic logic [31:0] check_code(input logic [31:0] crc);
      logic [7:0] c0, c1, c2, c3;
      {c3, c2, c1, c0} = crc;
      return {c1 >> 4, 8'(c0 << 5), c3 >> 2, 8'(c2 << 3)};
   endfunction

   function automatic string item_text(input rsp_type r);
      return $sformatf("kind=%0d byte=%02h index=%0d status=%0d seq=%08h %s%0d %s%0d",
                       r.kind, r.data, r.index, r.status, r.seq,
                       "length=", r.length, "sensor=", r.sensor);
   endfunction

   function automatic void clear_frame_state();
      pos_cnt   = 0;
      err_first = ST_OK;
      crc_run   = '1;
      crc_done  = '0;
      decl_len  = '0;
      seq_acc   = '0;
      crc_seen  = '0;
      code_seen = '0;
      type_ok   = 1'b1;
   endfunction

   function automatic void note_error(input status_type code);
      if (err_first == ST_OK) err_first = code;
   endfunction

   // One accepted byte through the parser; returns 1 when it yields a result.
   function automatic bit frame_step(input logic [7:0] b, input logic last,
                                     output rsp_type r);
      int unsigned     pos;
      int unsigned     idx;
      longint unsigned off;
      longint unsigned crc_start;
      bit              fwd;
      kind_type        kind;
      status_type      st;
      pos       = pos_cnt;
      crc_start = 64'(decl_len) + PAY_POS;
      fwd       = 1'b0;
      kind      = KIND_TYPE;
      idx       = 0;
      r         = '0;

      if (pos < VER_POS) begin
         if (b != MAGIC_WORD[31 - 8*pos -: 8]) note_error(ST_MAGIC);
      end else if (pos < VER_POS + 4) begin
         if (b != 8'd1) begin
            case (pos - VER_POS)
               0:       note_error(ST_MAIN_VER);
               1:       note_error(ST_SUB_VER);
               2:       note_error(ST_CRC_FLAG);
               default: note_error(ST_CODE_FLAG);
            endcase
         end
      end else if (pos >= SEQ_POS && pos < SEQ_POS + 4) begin
         seq_acc = {seq_acc[23:0], b};
      end else if (pos >= TYPE_POS && pos < LEN_POS) begin
         idx = pos - TYPE_POS;
         if (idx < SENSOR_LEN && b != sensor_byte(idx)) type_ok = 1'b0;
         fwd  = 1'b1;
         kind = KIND_TYPE;
      end else if (pos >= LEN_POS && pos < PAY_POS) begin
         decl_len = {decl_len[23:0], b};
      end else if (pos >= PAY_POS) begin
         off = pos - PAY_POS;
         if (off < decl_len && off < MAX_PAYLOAD) begin
            fwd  = 1'b1;
            kind = KIND_PAYLOAD;
            idx  = 32'(off);
         end
         // trailer is only located when the declared length is sane
         if (decl_len <= MAX_PAYLOAD) begin
            if (pos >= crc_start && pos < crc_start + 4)
               crc_seen = {crc_seen[23:0], b};
            else if (pos >= crc_start + 4 && pos < crc_start + 8)
               code_seen = {code_seen[23:0], b};
         end
      end

      // CRC covers everything up to the end of the declared payload
      if (pos < PAY_POS || pos < crc_start) begin
         crc_run  = crc_update(crc_run, b);
         crc_done = ~crc_run;
      end

      if (pos_cnt < POS_LIMIT) pos_cnt++;

      if (last) begin
         st = err_first;
         if (pos_cnt <= MIN_FRAME) begin
            st = ST_SHORT;
         end else if (st == ST_OK) begin
            if (decl_len > MAX_PAYLOAD)                 st = ST_OVERFLOW;
            else if (pos_cnt < crc_start + 8)           st = ST_LENGTH;
            else if (crc_seen != crc_done)              st = ST_CRC;
            else if (code_seen != check_code(crc_seen)) st = ST_CODE;
            else if (pos_cnt != crc_start + 8)          st = ST_LENGTH;
         end
         r.kind   = KIND_STATUS;
         r.status = st;
         r.seq    = seq_acc;
         if (st == ST_OK) begin
            r.length = decl_len[LENGTH_W-1:0];
            r.sensor = type_ok;
         end
         clear_frame_state();
         return 1'b1;
      end
      if (fwd) begin
         r.kind  = kind;
         r.data  = b;
         r.index = idx[INDEX_W-1:0];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Builds one frame of the given kind and queues its bytes for sending.
   task automatic queue_frame(input frame_kind fk, input int unsigned plen,
                              input int unsigned extra, input type_pick tp);
      logic [7:0]  frm[$];
      logic [7:0]  ty[TYPE_LEN];
      logic [31:0] word;
      logic [31:0] crc_word;
      logic [7:0]  v;
      int unsigned n;
      req_type     it;
      if (tp == TY_ANY) tp = type_pick'($urandom_range(TY_ARBITRARY));
      if (fk == FR_NOISE) begin
         repeat (extra + 1) frm.push_back(8'($urandom_range(255)));
      end else begin
         for (int i = 0; i < 4; i++) frm.push_back(MAGIC_WORD[31 - 8*i -: 8]);
         repeat (4) frm.push_back(8'd1);
         repeat (SEQ_POS - 8) frm.push_back(8'($urandom_range(255)));
         word = $urandom();
         for (int i = 0; i < 4; i++) frm.push_back(word[31 - 8*i -: 8]);

         foreach (ty[i]) ty[i] = 8'($urandom_range(255));
         if (tp != TY_ARBITRARY) begin
            for (int i = 0; i < SENSOR_LEN; i++) ty[i] = sensor_byte(i);
            if (tp == TY_UNTERMINATED) ty[SENSOR_LEN-1] = 8'($urandom_range(1, 255));
            if (tp == TY_MISSPELT)
               ty[$urandom_range(SENSOR_LEN - 2)] ^= 8'($urandom_range(1, 255));
         end
         foreach (ty[i]) frm.push_back(ty[i]);

         word = plen;
         for (int i = 0; i < 4; i++) frm.push_back(word[31 - 8*i -: 8]);

         if (fk == FR_OVERFLOW) begin
            // no usable trailer behind a bad length, just some bytes
            repeat (extra) frm.push_back(8'($urandom_range(255)));
         end else begin
            repeat (plen) frm.push_back(8'($urandom_range(255)));
            crc_word = '1;
            foreach (frm[i]) crc_word = crc_update(crc_word, frm[i]);
            crc_word = ~crc_word;
            if (fk == FR_BAD_CRC) crc_word ^= 32'd1 << $urandom_range(31);
            for (int i = 0; i < 4; i++) frm.push_back(crc_word[31 - 8*i -: 8]);
            word = check_code(crc_word);
            if (fk == FR_BAD_CODE) word ^= 32'd1 << $urandom_range(31);
            for (int i = 0; i < 4; i++) frm.push_back(word[31 - 8*i -: 8]);
         end

         // header damage goes in after the CRC, so the CRC is off as well
         case (fk)
            FR_MAGIC:
               frm[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
            FR_MAIN_VER, FR_SUB_VER, FR_CRC_FLAG, FR_CODE_FLAG: begin
               v = 8'($urandom_range(255));
               if (v == 8'd1) v = 8'd0;
               frm[VER_POS + (fk - FR_MAIN_VER)] = v;
            end
            FR_CUT_TAIL:
               repeat (extra) void'(frm.pop_back());
            FR_EXTRA:
               repeat (extra) frm.push_back(8'($urandom_range(255)));
            FR_SHORT: begin
               n = $urandom_range(1, MIN_FRAME);
               while (frm.size() > n) void'(frm.pop_back());
            end
            default: ;
         endcase
      end

      foreach (frm[i]) begin
         it.data = frm[i];
         it.last = (i == frm.size() - 1);
         byte_queue.push_back(it);
      end
      items_queued += frm.size();
   endtask

   // Holds off until everything sent has been answered and the pipe is empty.
   task automatic wait_idle();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_if.valid || expected_rsp.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly clean frames with random content, the rest damaged or noise.
   task automatic run_random(input int unsigned budget);
      int unsigned start;
      int unsigned frames;
      int unsigned plen;
      int unsigned extra;
      frame_kind   fk;
      start  = items_queued;
      frames = 0;
      while (items_queued - start < budget) begin
         fk = ($urandom_range(99) < 55) ? FR_GOOD
                                        : frame_kind'($urandom_range(FR_NOISE, FR_MAGIC));
         plen  = $urandom_range(24);
         extra = $urandom_range(1, 8);
         case (fk)
            FR_OVERFLOW: begin
               plen  = ($urandom_range(3) == 0) ? ($urandom() | 32'h0001_0000)
                                                : MAX_PAYLOAD + $urandom_range(1, 3000);
               extra = $urandom_range(40);
            end
            FR_NOISE: extra = $urandom_range(90);
            default: ;
         endcase
         queue_frame(fk, plen, extra, TY_ANY);
         frames++;
         // sender pauses now and then until every result is back
         if (frames % 6 == 0) wait_idle();
      end
   endtask

   // driver: next byte when the slot is free, random gaps
   always @(posedge clock) begin
      req_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (byte_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            nxt = byte_queue.pop_front();
            req_if.valid     <= 1'b1;
            req_if.rx_byte   <= nxt.data;
            req_if.frame_end <= nxt.last;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor: predict on byte accept, then check any result taken this edge
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         clear_frame_state();
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
         if (req_if.valid && req_if.ready) begin
            if (frame_step(req_if.rx_byte, req_if.frame_end, want))
               expected_rsp.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind   = rsp_if.result_kind;
            got.data   = rsp_if.out_byte;
            got.index  = rsp_if.byte_index;
            got.status = rsp_if.status_code;
            got.seq    = rsp_if.sequence_number;
            got.length = rsp_if.payload_length;
            got.sensor = rsp_if.is_sensor;
            if (expected_rsp.size() == 0) begin
               errors_seen++;
               if (errors_seen <= MAX_REPORTS)
                  $display("%0t: unexpected result, expected none, actual %s",
                           $realtime, item_text(got));
            end else begin
               want = expected_rsp.pop_front();
               if (got.kind !== want.kind || got.data !== want.data ||
                   got.index !== want.index || got.status !== want.status ||
                   got.seq !== want.seq || got.length !== want.length ||
                   got.sensor !== want.sensor) begin
                  errors_seen++;
                  if (errors_seen <= MAX_REPORTS)
                     $display("%0t: mismatch, expected %s, actual %s",
                              $realtime, item_text(want), item_text(got));
               end
            end
         end
      end
   end

   // watchdog on transfers in either direction
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.rx_byte   = '0;
      req_if.frame_end = 1'b0;
      rsp_if.ready     = 1'b0;
      items_queued     = 0;
      errors_seen      = 0;
      stall_cycles     = 0;
      src_idle_pct     = 11;
      sink_idle_pct    = 78;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: lone byte, short frames, each header fault, trailer faults
      queue_frame(FR_NOISE, 0, 0, TY_ANY);
      queue_frame(FR_SHORT, 4, 0, TY_ANY);
      queue_frame(FR_GOOD, 1, 0, TY_SENSOR);
      queue_frame(FR_GOOD, 0, 0, TY_SENSOR);      // empty payload is still too short
      queue_frame(FR_GOOD, 5, 0, TY_UNTERMINATED);
      queue_frame(FR_GOOD, 3, 0, TY_MISSPELT);
      queue_frame(FR_MAGIC, 3, 0, TY_SENSOR);
      queue_frame(FR_MAIN_VER, 3, 0, TY_ANY);
      queue_frame(FR_SUB_VER, 3, 0, TY_ANY);
      queue_frame(FR_CRC_FLAG, 3, 0, TY_ANY);
      queue_frame(FR_CODE_FLAG, 3, 0, TY_ANY);
      queue_frame(FR_BAD_CRC, 2, 0, TY_SENSOR);
      queue_frame(FR_BAD_CODE, 2, 0, TY_SENSOR);
      queue_frame(FR_CUT_TAIL, 6, 4, TY_ANY);
      queue_frame(FR_EXTRA, 6, 3, TY_ANY);
      queue_frame(FR_OVERFLOW, MAX_PAYLOAD + 1, 10, TY_SENSOR);
      wait_idle();

      run_random(PHASE_ITEMS);
      wait_idle();
      src_idle_pct  = 78;
      sink_idle_pct = 11;
      run_random(PHASE_ITEMS);
      wait_idle();
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      run_random(PHASE_ITEMS);
      wait_idle();

      if (errors_seen == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== framed_message_checker.f =====
rtl/fmc_pkg.sv
rtl/fmc_ifs.sv
rtl/fmc_parser.sv
rtl/framed_message_checker.sv
bench/tb_framed_message_checker.sv
